@@ rtl/core/rdc_pkg.sv @@
package rdc_pkg;

    // radix operation codes
    localparam logic [1:0] OP_DEC    = 2'd0;
    localparam logic [1:0] OP_OCT    = 2'd1;
    localparam logic [1:0] OP_HEX_LO = 2'd2;
    localparam logic [1:0] OP_HEX_UP = 2'd3;

    // length codes, the fourth code behaves like SIZE_32
    localparam logic [1:0] SIZE_32 = 2'd0;
    localparam logic [1:0] SIZE_64 = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;

    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_DIGITS = 22;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X_LO = 8'h78;
    localparam logic [7:0] CHAR_X_UP = 8'h58;
    localparam logic [7:0] CHAR_A_LO = 8'h61;
    localparam logic [7:0] CHAR_A_UP = 8'h41;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] value;
        logic [1:0]  size_mode;
        logic        alt_form;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_item;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'b0, d};
        end else begin
            c = (upper ? CHAR_A_UP : CHAR_A_LO) + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/radix_digit_converter.sv @@
// channel  | direction | handshake                  | payload
// input    | in        | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
// output   | out       | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// one item at a time: ready only while idle
// decimal runs a shift-add-3 unit over all VALUE_BITS bits, octal and hex load their digits directly
// then leading zero digits are skipped, then the optional prefix and the digit chars are sent
// output register is held while i_out_ready is low, the prefix and digit states wait with it
// synchronous active-low reset returns the sequencer to idle and empties the output
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int PTR_W = $clog2(MAX_DIGITS);
    localparam int EXT_W = (4 * MAX_DIGITS > VALUE_BITS) ? 4 * MAX_DIGITS : VALUE_BITS;
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(MAX_DIGITS - 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_CONV    = 6'b000010,
        S_SKIP    = 6'b000100,
        S_PREFIX0 = 6'b001000,
        S_PREFIX1 = 6'b010000,
        S_DIGITS  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [1:0]            r_op, n_op;
    logic                  r_prefix, n_prefix;
    logic [VALUE_BITS-1:0] r_work, n_work;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [PTR_W-1:0]      r_ptr, n_ptr;
    logic [3:0]            r_dig [MAX_DIGITS];
    logic [3:0]            n_dig [MAX_DIGITS];
    logic [3:0]            w_adj [MAX_DIGITS];
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_item, n_out_item;

    logic                  w_accept;
    logic                  w_load;
    logic [VALUE_BITS-1:0] w_full;
    logic [VALUE_BITS-1:0] w_kept;
    logic [EXT_W-1:0]      w_ext;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_full = i_in_item.value[VALUE_BITS-1:0];

    always_comb begin
        case (i_in_item.size_mode)
            SIZE_64: w_kept = w_full;
            SIZE_16: w_kept = w_full & VALUE_BITS'(16'hFFFF);
            default: w_kept = w_full & VALUE_BITS'(32'hFFFF_FFFF);
        endcase
    end

    assign w_ext = EXT_W'(w_kept);

    // add-3 correction on every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_adj[i] = (r_dig[i] >= 4'd5) ? (r_dig[i] + 4'd3) : r_dig[i];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_prefix    = r_prefix;
        n_work      = r_work;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_in_item.operation;
                    n_prefix = i_in_item.alt_form && (w_full != '0)
                               && (i_in_item.operation != OP_DEC);
                    n_work   = w_kept;
                    n_cnt    = CNT_W'(VALUE_BITS);
                    n_ptr    = PTR_TOP;
                    for (int i = 0; i < MAX_DIGITS; i++) begin
                        case (i_in_item.operation)
                            OP_DEC:  n_dig[i] = 4'd0;
                            OP_OCT:  n_dig[i] = {1'b0, w_ext[3*i +: 3]};
                            default: n_dig[i] = w_ext[4*i +: 4];
                        endcase
                    end
                    n_state = (i_in_item.operation == OP_DEC) ? S_CONV : S_SKIP;
                end
            end
            S_CONV: begin
                // bcd digits above MAX_DIGITS fall off the top
                for (int i = 0; i < MAX_DIGITS; i++) begin
                    if (i == 0) begin
                        n_dig[i] = {w_adj[i][2:0], r_work[VALUE_BITS-1]};
                    end else begin
                        n_dig[i] = {w_adj[i][2:0], w_adj[i-1][3]};
                    end
                end
                n_work = r_work << 1;
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (r_dig[r_ptr] == 4'd0 && r_ptr != '0) begin
                    n_ptr = r_ptr - PTR_W'(1);
                end else begin
                    n_state = r_prefix ? S_PREFIX0 : S_DIGITS;
                end
            end
            S_PREFIX0: begin
                if (w_load) begin
                    n_out_valid         = 1'b1;
                    n_out_item.out_char = CHAR_ZERO;
                    n_out_item.last     = 1'b0;
                    n_state             = (r_op == OP_OCT) ? S_DIGITS : S_PREFIX1;
                end
            end
            S_PREFIX1: begin
                if (w_load) begin
                    n_out_valid         = 1'b1;
                    n_out_item.out_char = (r_op == OP_HEX_UP) ? CHAR_X_UP : CHAR_X_LO;
                    n_out_item.last     = 1'b0;
                    n_state             = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (w_load) begin
                    n_out_valid         = 1'b1;
                    n_out_item.out_char = digit_char(r_dig[r_ptr], r_op == OP_HEX_UP);
                    n_out_item.last     = (r_ptr == '0);
                    if (r_ptr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr = r_ptr - PTR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_prefix   <= n_prefix;
        r_work     <= n_work;
        r_cnt      <= n_cnt;
        r_ptr      <= n_ptr;
        r_dig      <= n_dig;
        r_out_item <= n_out_item;
    end

    // an accepted item goes straight into conversion or the zero skip
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV || r_state == S_SKIP))
        else $error("accepted item did not start conversion");

    // conversion leaves the digit pointer at the top
    a_conv_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_ptr == PTR_TOP))
        else $error("digit pointer moved during conversion");

    // octal digits never exceed seven
    a_oct_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SKIP || r_state == S_DIGITS) && r_op == OP_OCT)
        |-> (r_dig[r_ptr][3] == 1'b0))
        else $error("octal digit out of range");

    // the least significant digit closes the item and frees the input
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGITS && w_load && r_ptr == '0)
        |=> (o_out_valid && o_out_item.last && r_state == S_IDLE))
        else $error("final digit not marked last");

endmodule
